// File: hw/rtl/des_pkg.sv
// DES package: permutation tables, S-boxes and round helper functions.
// Used by the cipher top level; depends on nothing else.
package des_pkg;

   localparam int unsigned ROUNDS = 16;
   localparam int unsigned STAGES = ROUNDS + 1;

   localparam logic [6:0] IP_TAB [64] = '{
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
      7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
   };

   localparam logic [6:0] FP_TAB [64] = '{
      7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
      7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
      7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
      7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
      7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
      7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
      7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
      7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
   };

   localparam logic [6:0] PC1_TAB [56] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
      7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
      7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55,
      7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
      7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21,
      7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   localparam logic [1:0] ROT_TAB [16] = '{
      2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
   };

   localparam logic [5:0] PC2_TAB [48] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
      6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
      6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
      6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
      6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   localparam logic [5:0] E_TAB [48] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
      6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
      6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
      6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
      6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   localparam logic [5:0] P_TAB [32] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
   };

   // indexed by box, then {row, column}
   localparam logic [3:0] SBOX_TAB [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
   };

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   function automatic logic [63:0] init_perm(input logic [63:0] x);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         r[63 - i] = x[64 - int'(IP_TAB[i])];
      end
      return r;
   endfunction

   function automatic logic [63:0] final_perm(input logic [63:0] x);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         r[63 - i] = x[64 - int'(FP_TAB[i])];
      end
      return r;
   endfunction

   // Round key for a constant round number: pure wiring of the key.
   function automatic logic [47:0] round_key(input logic [63:0] key, input logic [3:0] rnd);
      logic [55:0] cd;
      logic [27:0] c;
      logic [27:0] d;
      logic [55:0] kk;
      logic [47:0] k;
      cd = '0;
      for (int i = 0; i < 56; i++) begin
         cd[55 - i] = key[64 - int'(PC1_TAB[i])];
      end
      c = cd[55:28];
      d = cd[27:0];
      for (int j = 0; j < 16; j++) begin
         if (j <= int'(rnd)) begin
            for (int s = 0; s < 2; s++) begin
               if (s < int'(ROT_TAB[j])) begin
                  c = {c[26:0], c[27]};
                  d = {d[26:0], d[27]};
               end
            end
         end
      end
      kk = {c, d};
      k = '0;
      for (int i = 0; i < 48; i++) begin
         k[47 - i] = kk[56 - int'(PC2_TAB[i])];
      end
      return k;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] e;
      logic [47:0] x;
      logic [5:0]  b;
      logic [31:0] s;
      logic [31:0] p;
      e = '0;
      for (int i = 0; i < 48; i++) begin
         e[47 - i] = r[32 - int'(E_TAB[i])];
      end
      x = e ^ k;
      s = '0;
      for (int j = 0; j < 8; j++) begin
         b = x[47 - 6 * j -: 6];
         s[31 - 4 * j -: 4] = SBOX_TAB[j][{b[5], b[0], b[4:1]}];
      end
      p = '0;
      for (int i = 0; i < 32; i++) begin
         p[31 - i] = s[32 - int'(P_TAB[i])];
      end
      return p;
   endfunction

endpackage

// File: hw/rtl/des_block_cipher_top.sv
// DES ECB block cipher, one block per cycle while the result side does not stall, through a round-per-stage pipeline.
// Depends on des_pkg for tables and round functions.
//
// Each accepted beat carries one 64-bit block and a direction flag; exactly one
// result beat comes back per block, in order. The pipeline has an input stage
// that applies the initial permutation, then sixteen stages of one Feistel round
// each; a block's result is shown from the last round stage, and with no stall
// a new block can be taken every cycle. A stall on the result side holds each full
// stage with no empty stage ahead; empty stages still fill, so req_stall rises only
// once all seventeen stages hold a block. The round keys are wired from the key
// register, so a key write applies to every block accepted after it; write it only while idle.
module des_block_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [63:0] req_data_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_block,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_cipher_key
);

   localparam int unsigned LAST = des_pkg::STAGES - 1;

   logic [63:0] key_ff;
   logic [63:0] key_in;
   logic [47:0] rkey [des_pkg::ROUNDS];

   logic        stg_vld_ff [des_pkg::STAGES];
   logic        stg_vld_in [des_pkg::STAGES];
   logic        stg_cmd_ff [des_pkg::STAGES];
   logic        stg_cmd_in [des_pkg::STAGES];
   logic [31:0] stg_l_ff   [des_pkg::STAGES];
   logic [31:0] stg_l_in   [des_pkg::STAGES];
   logic [31:0] stg_r_ff   [des_pkg::STAGES];
   logic [31:0] stg_r_in   [des_pkg::STAGES];
   logic        stg_rdy    [des_pkg::STAGES];
   logic [63:0] ip_block;

   assign csr_ready = 1'b1;
   assign key_in    = (csr_valid && csr_ready) ? csr_cipher_key : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   for (genvar g = 0; g < des_pkg::ROUNDS; g++) begin : g_rkey
      assign rkey[g] = des_pkg::round_key(key_ff, 4'(g));
   end

   // advance a stage when it is empty or its successor advances
   assign stg_rdy[LAST] = !stg_vld_ff[LAST] || !rsp_stall;
   for (genvar g = 0; g < LAST; g++) begin : g_rdy
      assign stg_rdy[g] = !stg_vld_ff[g] || stg_rdy[g + 1];
   end

   assign req_stall = !stg_rdy[0];
   assign ip_block  = des_pkg::init_perm(req_data_block);

   assign stg_vld_in[0] = req_valid;
   assign stg_cmd_in[0] = req_cmd;
   assign stg_l_in[0]   = ip_block[63:32];
   assign stg_r_in[0]   = ip_block[31:0];

   for (genvar g = 1; g < des_pkg::STAGES; g++) begin : g_round
      logic [47:0] k_sel;
      assign k_sel = (stg_cmd_ff[g - 1] == des_pkg::CMD_DECRYPT) ?
                     rkey[des_pkg::ROUNDS - g] : rkey[g - 1];
      assign stg_vld_in[g] = stg_vld_ff[g - 1];
      assign stg_cmd_in[g] = stg_cmd_ff[g - 1];
      assign stg_l_in[g]   = stg_r_ff[g - 1];
      assign stg_r_in[g]   = stg_l_ff[g - 1] ^ des_pkg::feistel(stg_r_ff[g - 1], k_sel);
   end

   for (genvar g = 0; g < des_pkg::STAGES; g++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_vld_ff[g] <= 1'b0;
         end else if (stg_rdy[g]) begin
            stg_vld_ff[g] <= stg_vld_in[g];
         end
      end

      always_ff @(posedge clock) begin
         if (stg_rdy[g]) begin
            stg_cmd_ff[g] <= stg_cmd_in[g];
            stg_l_ff[g]   <= stg_l_in[g];
            stg_r_ff[g]   <= stg_r_in[g];
         end
      end
   end

   assign rsp_valid        = stg_vld_ff[LAST];
   assign rsp_result_block = des_pkg::final_perm({stg_r_ff[LAST], stg_l_ff[LAST]});

endmodule

// File: hw/rtl/des_chk.sv
// Port-level checker for the DES cipher top level, attached by bind.
// Depends only on the top level's ports.
module des_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_result_block
);

   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output side can drain");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result beat dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_result_block))
      else $error("stalled result beat changed");

endmodule

bind des_block_cipher_top des_chk u_des_chk (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_block (rsp_result_block)
);
